@@ sv/u8cp_pkg.sv @@
// u8cp_pkg: shared types and constants for the utf-8 to code point decoder
// used by u8cp_step and utf8_to_codepoint_decoder_top; no dependencies
`default_nettype none

package u8cp_pkg;

    // sequence phase: how many continuation bytes are still expected
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ONE  = 2'd1,
        PH_TWO  = 2'd2
    } phase_t;

    // byte class boundaries and payload masks
    localparam logic [7:0] LIM_ASCII = 8'h80;
    localparam logic [7:0] LIM_CONT  = 8'hC0;
    localparam logic [7:0] LIM_LEAD2 = 8'hE0;
    localparam logic [7:0] LIM_LEAD3 = 8'hF0;
    localparam logic [7:0] MASK_LEAD2 = 8'h1F;
    localparam logic [7:0] MASK_LEAD3 = 8'h0F;
    localparam logic [7:0] MASK_CONT  = 8'h3F;

    // decoder state carried from one byte to the next
    typedef struct packed {
        phase_t      phase;
        logic [15:0] partial;
    } dec_state_t;

    // outcome of one byte: next state and an optional code point
    typedef struct packed {
        dec_state_t  state;
        logic        emit;
        logic [15:0] code_point;
    } step_result_t;

endpackage

`default_nettype wire

@@ sv/utf8_to_codepoint_decoder_top.sv @@
// utf8_to_codepoint_decoder_top: input register, decode step and result register
// depends on u8cp_pkg and u8cp_step
//
//  channel | ports                          | direction | width
//  input   | s_valid, s_ready, s_byte_in    | in        | 8
//  result  | m_valid, m_ready, m_code_point | out       | 16
//
// one byte per cycle sustained while the result slot is free; a byte taken sits in the input register,
// and the decode step writes its result from there into the result register, which drives m_valid.
// aresetn is synchronous and active low; it clears both valid flags and the state.
// a stall on m_ready holds the result; the input register drains bytes, also those
// that make no result, only once the result slot is free, so s_ready can drop while m_ready is low.
`default_nettype none

module utf8_to_codepoint_decoder_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_byte_in,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_code_point
);

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    u8cp_pkg::dec_state_t   state_reg;
    logic                   out_valid_reg;
    logic [15:0]            out_cp_reg;

    logic                   out_free;
    logic                   fire;
    u8cp_pkg::step_result_t step_res;

    // handshake control
    assign out_free = !out_valid_reg || m_ready;
    assign fire     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || fire;

    // decode step
    u8cp_step u_step (
        .cur      (state_reg),
        .byte_val (in_byte_reg),
        .res      (step_res)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_byte_reg <= s_byte_in;
        end
    end

    // decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase   <= u8cp_pkg::PH_IDLE;
            state_reg.partial <= 16'h0000;
        end else if (fire) begin
            state_reg <= step_res.state;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= fire && step_res.emit;
        end
        if (fire && step_res.emit) begin
            out_cp_reg <= step_res.code_point;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_code_point = out_cp_reg;

endmodule

`default_nettype wire

@@ sv/u8cp_step.sv @@
// u8cp_step: combinational decode of one utf-8 byte against the held state
// depends on u8cp_pkg
`default_nettype none

module u8cp_step (
    input  wire u8cp_pkg::dec_state_t   cur,
    input  wire logic [7:0]             byte_val,
    output u8cp_pkg::step_result_t      res
);

    logic                 is_cont;
    logic                 seq_open;
    u8cp_pkg::step_result_t fresh;

    assign is_cont  = (byte_val >= u8cp_pkg::LIM_ASCII) && (byte_val < u8cp_pkg::LIM_CONT);
    assign seq_open = (cur.phase == u8cp_pkg::PH_ONE) || (cur.phase == u8cp_pkg::PH_TWO);

    // handling of a byte as a lead, starting from idle
    always_comb begin
        fresh.state.phase   = u8cp_pkg::PH_IDLE;
        fresh.state.partial = seq_open ? 16'h0000 : cur.partial;
        fresh.emit          = 1'b0;
        fresh.code_point    = {8'h00, byte_val};
        if (byte_val < u8cp_pkg::LIM_ASCII) begin
            fresh.emit          = 1'b1;
            fresh.state.partial = 16'h0000;
        end else if (byte_val < u8cp_pkg::LIM_CONT) begin
            // stray continuation, dropped
            fresh.emit = 1'b0;
        end else if (byte_val < u8cp_pkg::LIM_LEAD2) begin
            fresh.state.phase   = u8cp_pkg::PH_ONE;
            fresh.state.partial = {5'd0, byte_val[4:0] & u8cp_pkg::MASK_LEAD2[4:0], 6'd0};
        end else if (byte_val < u8cp_pkg::LIM_LEAD3) begin
            fresh.state.phase   = u8cp_pkg::PH_TWO;
            fresh.state.partial = {byte_val[3:0] & u8cp_pkg::MASK_LEAD3[3:0], 12'd0};
        end else begin
            // four-byte and invalid leads, dropped
            fresh.state.partial = 16'h0000;
        end
    end

    // continuation into an open sequence, else restart as a lead
    always_comb begin
        res = fresh;
        if (seq_open && is_cont) begin
            case (cur.phase)
                u8cp_pkg::PH_TWO: begin
                    res.state.phase   = u8cp_pkg::PH_ONE;
                    res.state.partial = cur.partial |
                        {4'd0, byte_val[5:0] & u8cp_pkg::MASK_CONT[5:0], 6'd0};
                    res.emit          = 1'b0;
                    res.code_point    = 16'h0000;
                end
                default: begin
                    res.state.phase   = u8cp_pkg::PH_IDLE;
                    res.state.partial = 16'h0000;
                    res.emit          = 1'b1;
                    res.code_point    = cur.partial |
                        {10'd0, byte_val[5:0] & u8cp_pkg::MASK_CONT[5:0]};
                end
            endcase
        end
    end

endmodule

`default_nettype wire
